// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    RSP_INSERTED = 2'd0,
    RSP_REMOVED  = 2'd1,
    RSP_EMPTY    = 2'd2,
    RSP_FULL     = 2'd3
  } rsp_status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_FULL,
    OP_EMPTY
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic exec;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   event_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, req_type, event_id, priority_req, input ready);
  modport sink (input valid, req_type, event_id, priority_req, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/spq_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface spq_rsp_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_id;
  logic [PRIO_W-1:0] out_priority;
  logic [1:0]        status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, out_id, out_priority, status, occupancy, input ready);
  modport sink (input valid, out_id, out_priority, status, occupancy, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/stable_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stable priority queue of up to CAPACITY entries (event id and 8-bit priority), kept
// sorted with the smallest priority at the head and equal priorities in arrival order.
// Every request beat (insert or remove) gives exactly one response beat with status
// inserted, removed, empty or full, plus the occupancy after the request. A request is
// handled in the cycle it is accepted: all slots compare against the new priority in
// parallel and shift by one in a single step, and the response sits in a register the
// next cycle. One request per cycle is taken as long as the response side keeps up;
// a response not yet taken holds off the next request.
module stable_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  spq_req_if.sink        req_i,
  spq_rsp_if.source      rsp_o
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .req_type_i  (req_i.req_type),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .event_id_i     (req_i.event_id),
    .priority_req_i (req_i.priority_req),
    .stat_o         (stat),
    .out_id_o       (rsp_o.out_id),
    .out_priority_o (rsp_o.out_priority),
    .status_o       (rsp_o.status),
    .occupancy_o    (rsp_o.occupancy)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/spq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o
);
  import spq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ready_i && !accept) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_HOLD: begin
        in_ready_o  = out_ready_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o.exec = accept;
    cmd_o.op   = OP_NONE;
    if (accept) begin
      if (req_type_i == REQ_INSERT) begin
        cmd_o.op = stat_i.full ? OP_FULL : OP_INSERT;
      end else begin
        cmd_o.op = stat_i.empty ? OP_EMPTY : OP_REMOVE;
      end
    end
  end

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("result beat missing after accepted request");

  a_no_op_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_o.exec |-> cmd_o.op == OP_NONE)
    else $error("datapath command without accepted request");

  a_hold_until_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result beat dropped before taken");

endmodule

`default_nettype wire

// ----- hw/rtl/spq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::cmd_t             cmd_i,
  input  logic [spq_pkg::ID_W-1:0]   event_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] priority_req_i,
  output spq_pkg::stat_t            stat_o,
  output logic [spq_pkg::ID_W-1:0]   out_id_o,
  output logic [spq_pkg::PRIO_W-1:0] out_priority_o,
  output logic [1:0]                status_o,
  output logic [spq_pkg::OCC_W-1:0]  occupancy_o
);
  import spq_pkg::*;

  logic [ID_W-1:0]   id_q   [CAPACITY];
  logic [ID_W-1:0]   id_d   [CAPACITY];
  logic [PRIO_W-1:0] prio_q [CAPACITY];
  logic [PRIO_W-1:0] prio_d [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;

  logic [CAPACITY-1:0] le;
  logic [CAPACITY-1:0] le_prev;

  logic [ID_W-1:0]      out_id_q;
  logic [PRIO_W-1:0]    out_priority_q;
  rsp_status_e          status_q;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign stat_o.full  = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty = (count_q == '0);

  // per slot compare, true for held entries that stay ahead of the new one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign le[i] = (count_q > CNT_W'(i)) && (prio_q[i] <= priority_req_i);

    if (i == 0) begin : g_head
      assign le_prev[i] = 1'b1;
    end else begin : g_body
      assign le_prev[i] = le[i-1];
    end

    always_comb begin
      id_d[i]   = id_q[i];
      prio_d[i] = prio_q[i];
      case (cmd_i.op)
        OP_INSERT: begin
          if (!le[i]) begin
            if (le_prev[i]) begin
              id_d[i]   = event_id_i;
              prio_d[i] = priority_req_i;
            end else begin
              id_d[i]   = id_q[(i == 0) ? 0 : i-1];
              prio_d[i] = prio_q[(i == 0) ? 0 : i-1];
            end
          end
        end
        OP_REMOVE: begin
          if (i < CAPACITY - 1) begin
            id_d[i]   = id_q[(i < CAPACITY - 1) ? i+1 : i];
            prio_d[i] = prio_q[(i < CAPACITY - 1) ? i+1 : i];
          end
        end
        default: begin
          id_d[i]   = id_q[i];
          prio_d[i] = prio_q[i];
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      id_q[i]   <= id_d[i];
      prio_q[i] <= prio_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_INSERT: count_d = count_q + CNT_W'(1);
      OP_REMOVE: count_d = count_q - CNT_W'(1);
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_id_q       <= '0;
      out_priority_q <= '0;
      case (cmd_i.op)
        OP_INSERT: status_q <= RSP_INSERTED;
        OP_REMOVE: begin
          status_q       <= RSP_REMOVED;
          out_id_q       <= id_q[0];
          out_priority_q <= prio_q[0];
        end
        OP_FULL:   status_q <= RSP_FULL;
        OP_EMPTY:  status_q <= RSP_EMPTY;
        default:   status_q <= RSP_EMPTY;
      endcase
    end
  end

  assign occ_wide       = {{OCC_W{1'b0}}, count_q};
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_priority_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_wide[OCC_W-1:0];

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_remove_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_REMOVE |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not drop one entry");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> prio_q[0] <= prio_q[1])
    else $error("head entries out of order");

endmodule

`default_nettype wire

// ----- tb/stable_priority_queue_chk.sv -----
`timescale 1ns / 1ps

module stable_priority_queue_chk
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_req_if          req_i,
  spq_rsp_if          rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned rsp_cnt_o,
  output int unsigned open_cnt_o
);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    rsp_status_e       status;
    logic [OCC_W-1:0]  occ;
  } spq_rsp_t;

  logic [ID_W-1:0]   sorted_ids   [CAPACITY];
  logic [PRIO_W-1:0] sorted_prios [CAPACITY];
  int unsigned       held_cnt;
  spq_rsp_t          pending_rsp_q[$];

  // updates the sorted copy and returns the response the request should give
  function automatic spq_rsp_t serve_request(req_type_e kind, logic [ID_W-1:0] id,
                                             logic [PRIO_W-1:0] prio);
    spq_rsp_t    r;
    int unsigned pos;
    r = '0;
    if (kind == REQ_INSERT) begin
      if (held_cnt >= CAPACITY) begin
        r.status = RSP_FULL;
      end else begin
        pos = 0;
        // stable: go past every entry of lower or equal priority
        while (pos < held_cnt && sorted_prios[pos] <= prio) pos++;
        for (int i = held_cnt; i > pos; i--) begin
          sorted_ids[i]   = sorted_ids[i-1];
          sorted_prios[i] = sorted_prios[i-1];
        end
        sorted_ids[pos]   = id;
        sorted_prios[pos] = prio;
        held_cnt++;
        r.status = RSP_INSERTED;
      end
    end else begin
      if (held_cnt == 0) begin
        r.status = RSP_EMPTY;
      end else begin
        r.id   = sorted_ids[0];
        r.prio = sorted_prios[0];
        for (int i = 1; i < held_cnt; i++) begin
          sorted_ids[i-1]   = sorted_ids[i];
          sorted_prios[i-1] = sorted_prios[i];
        end
        held_cnt--;
        r.status = RSP_REMOVED;
      end
    end
    r.occ = OCC_W'(held_cnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_rsp_t    want;
    int unsigned errs;
    if (!rst_ni) begin
      held_cnt = 0;
      pending_rsp_q.delete();
      fail_cnt_o <= 0;
      rsp_cnt_o  <= 0;
      open_cnt_o <= 0;
    end else begin
      errs = 0;
      if (rsp_i.valid && rsp_i.ready) begin
        rsp_cnt_o <= rsp_cnt_o + 1;
        if (pending_rsp_q.size() == 0) begin
          $error("response beat with no request outstanding");
          errs++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_i.out_id !== want.id) begin
            $error("out_id: expected %h, got %h", want.id, rsp_i.out_id);
            errs++;
          end
          if (rsp_i.out_priority !== want.prio) begin
            $error("out_priority: expected %h, got %h", want.prio, rsp_i.out_priority);
            errs++;
          end
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            errs++;
          end
          if (rsp_i.occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, rsp_i.occupancy);
            errs++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_rsp_q.push_back(serve_request(req_type_e'(req_i.req_type), req_i.event_id,
                                              req_i.priority_req));
      end
      fail_cnt_o <= fail_cnt_o + errs;
      open_cnt_o <= pending_rsp_q.size();
    end
  end

endmodule

// ----- tb/stable_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned RAND_ITEMS     = 1130;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic        clk_i;
  logic        rst_ni;
  bit          stall_en;
  int unsigned sent_cnt;
  int unsigned fail_cnt;
  int unsigned rsp_cnt;
  int unsigned open_cnt;
  int unsigned quiet_cycles;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  stable_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  stable_priority_queue_chk u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .fail_cnt_o (fail_cnt),
    .rsp_cnt_o  (rsp_cnt),
    .open_cnt_o (open_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= !(stall_en && $urandom_range(99) < 10);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[stable_priority_queue] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input req_type_e kind, input logic [ID_W-1:0] id,
                          input logic [PRIO_W-1:0] prio);
    while (stall_en && $urandom_range(99) < 10) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.event_id     <= id;
    req_if.priority_req <= prio;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  initial begin
    int unsigned       run_len;
    int unsigned       ins_pct;
    int unsigned       span;
    int unsigned       base;
    int unsigned       n;
    req_type_e         kind;
    logic [PRIO_W-1:0] prio;

    rst_ni              <= 1'b0;
    stall_en            = 1'b1;
    sent_cnt            = 0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_INSERT;
    req_if.event_id     <= '0;
    req_if.priority_req <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // remove from an empty queue, then fill with ties and extremes
    send_req(REQ_REMOVE, 16'hFFFF, 8'hFF);
    send_req(REQ_INSERT, 16'hFFFF, 8'hFF);
    send_req(REQ_INSERT, 16'h0000, 8'h00);
    send_req(REQ_INSERT, 16'h1234, 8'h00);
    send_req(REQ_INSERT, 16'hA5A5, 8'h80);
    for (int i = 0; i < CAPACITY - 4; i++) begin
      send_req(REQ_INSERT, ID_W'(16'h0100 + i), 8'h80);
    end
    // insert into a full queue is dropped
    send_req(REQ_INSERT, 16'hBEEF, 8'h01);
    repeat (4) send_req(REQ_REMOVE, 16'h5A5A, 8'h7F);

    n = 0;
    while (n < RAND_ITEMS) begin
      run_len = $urandom_range(60, 10);
      case ($urandom_range(2))
        0:       ins_pct = 20;
        1:       ins_pct = 50;
        default: ins_pct = 85;
      endcase
      case ($urandom_range(2))
        0:       span = 255;
        1:       span = 3;
        default: span = 15;
      endcase
      base = $urandom_range(255 - span);
      for (int k = 0; k < run_len && n < RAND_ITEMS; k++) begin
        stall_en = !(n >= 400 && n < 700);
        kind = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
        prio = PRIO_W'(base + $urandom_range(span));
        send_req(kind, ID_W'($urandom), prio);
        n++;
      end
    end
    req_if.valid <= 1'b0;
    stall_en = 1'b1;

    while (rsp_cnt != sent_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("[stable_priority_queue] OK");
    end else begin
      $display("[stable_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/stable_priority_queue.sv
tb/stable_priority_queue_chk.sv
tb/stable_priority_queue_tb.sv
